/* design/preemptive_priority_aging_scheduler_core_defines.svh */
// assertion macros shared by the scheduler core
`ifndef PREEMPTIVE_PRIORITY_AGING_SCHEDULER_CORE_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_AGING_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PPAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler core: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler core: next-cycle check failed");

`endif

/* design/ppas_pkg.sv */
package ppas_pkg;

	// field widths
	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int PRI_W  = 8;
	localparam int DIV_W  = 8;
	localparam int CMD_W  = 2;
	localparam int CODE_W = 3;
	// priority * divisor + arrival fits in 17 bits
	localparam int KEY_W  = 17;

	localparam logic [DIV_W-1:0]  DIV_RESET = 8'd20;
	localparam logic [TIME_W-1:0] TIME_MAX  = 16'hFFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CODE_W-1:0] {
		RC_ADDED   = 3'd0,
		RC_FULL    = 3'd1,
		RC_RAN     = 3'd2,
		RC_IDLE    = 3'd3,
		RC_CLEARED = 3'd4
	} rsp_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_COMMIT
	} state_t;

	// one table entry as held in the entry ram
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRI_W-1:0]  prio;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] start;
	} entry_t;

	typedef struct packed {
		rsp_code_t         code;
		logic [TIME_W-1:0] tick_time;
		logic [ID_W-1:0]   run_id;
		logic              finished;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] response_time;
		logic [TIME_W-1:0] waiting_time;
		logic [TIME_W-1:0] turnaround_time;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic do_add;
		logic do_clear;
		logic scan_start;
		logic scan_run;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic out_free;
		logic scan_done;
	} ctrl_sts_t;

endpackage

/* design/ppas_if.sv */
// request channel: one command per transfer
interface ppas_req_if;
	import ppas_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ID_W-1:0]   proc_id;
	logic [TIME_W-1:0] arrival_time;
	logic [TIME_W-1:0] burst_length;
	logic [PRI_W-1:0]  base_priority;

	modport source (
		output valid, command, proc_id, arrival_time, burst_length, base_priority,
		input  ready
	);
	modport sink (
		input  valid, command, proc_id, arrival_time, burst_length, base_priority,
		output ready
	);
endinterface

// response channel: one result per transfer
interface ppas_rsp_if;
	import ppas_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] status;
	logic [TIME_W-1:0] tick_time;
	logic [ID_W-1:0]   run_id;
	logic              finished;
	logic [TIME_W-1:0] finish_time;
	logic [TIME_W-1:0] response_time;
	logic [TIME_W-1:0] waiting_time;
	logic [TIME_W-1:0] turnaround_time;

	modport source (
		output valid, status, tick_time, run_id, finished, finish_time,
		       response_time, waiting_time, turnaround_time,
		input  ready
	);
	modport sink (
		input  valid, status, tick_time, run_id, finished, finish_time,
		       response_time, waiting_time, turnaround_time,
		output ready
	);
endinterface

/* design/ppas_ram.sv */
module ppas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

/* design/ppas_datapath.sv */
module ppas_datapath #(
	parameter int MAX_PROCS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppas_pkg::ctrl_cmd_t           cmd,
	output ppas_pkg::ctrl_sts_t           sts,
	input  logic [ppas_pkg::CMD_W-1:0]    command,
	input  logic [ppas_pkg::ID_W-1:0]     proc_id,
	input  logic [ppas_pkg::TIME_W-1:0]   arrival_time,
	input  logic [ppas_pkg::TIME_W-1:0]   burst_length,
	input  logic [ppas_pkg::PRI_W-1:0]    base_priority,
	input  logic                          cfg_wr_en,
	input  logic [ppas_pkg::DIV_W-1:0]    cfg_wr_data,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output ppas_pkg::result_t             result
);
	import ppas_pkg::*;

	localparam int IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CntW = $clog2(MAX_PROCS + 1);
	localparam int RecW = $bits(entry_t);
	localparam logic [CntW-1:0] FullCount = CntW'(MAX_PROCS);

	// latched request
	cmd_t              cmd_q;
	entry_t            in_rec_q;

	// architectural state
	logic [DIV_W-1:0]     div_q;
	logic [TIME_W-1:0]    time_q;
	logic [CntW-1:0]      count_q;
	logic [MAX_PROCS-1:0] started_q;
	logic [MAX_PROCS-1:0] done_q;

	// scan pipeline
	logic [CntW-1:0]  scan_idx_q;
	logic             issue;
	logic             rv_s1;
	logic [IdxW-1:0]  ridx_s1;
	logic [RecW-1:0]  rd_data;
	entry_t           rd_rec;
	logic [TIME_W-1:0] prod;
	logic [KEY_W-1:0] key_c;
	logic             elig_c;
	logic             v_s2;
	logic             elig_s2;
	logic [KEY_W-1:0] key_s2;
	entry_t           rec_s2;
	logic [IdxW-1:0]  idx_s2;
	logic             better;

	// running best
	logic             found_q;
	logic [KEY_W-1:0] best_key_q;
	entry_t           best_rec_q;
	logic [IdxW-1:0]  best_idx_q;

	// commit arithmetic
	logic [TIME_W-1:0] time_inc;
	logic [TIME_W-1:0] start_v;
	logic [TIME_W-1:0] rem_new;
	logic [TIME_W-1:0] turn;
	logic [TIME_W-1:0] resp;
	logic [TIME_W-1:0] waited;
	entry_t            upd_rec;

	// ram write port and result
	logic              table_full;
	logic              add_wr;
	logic              upd_wr;
	logic              wr_en;
	logic [IdxW-1:0]   wr_addr;
	entry_t            wr_rec;
	logic              load_result;
	result_t           result_c;
	logic              rsp_valid_q;
	result_t           result_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q              <= cmd_t'(command);
			in_rec_q.id        <= proc_id;
			in_rec_q.arrival   <= arrival_time;
			in_rec_q.burst     <= burst_length;
			in_rec_q.prio      <= base_priority;
			in_rec_q.remaining <= burst_length;
			in_rec_q.start     <= '0;
		end
	end

	// aging divisor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIV_RESET;
		end else if (cfg_wr_en) begin
			div_q <= cfg_wr_data;
		end
	end

	assign table_full = (count_q == FullCount);
	assign add_wr     = cmd.do_add && !table_full;
	assign upd_wr     = cmd.commit && found_q;

	// entry read at the scan address, one per cycle
	assign issue = cmd.scan_run && (scan_idx_q < count_q);

	ppas_ram #(
		.WIDTH (RecW),
		.DEPTH (MAX_PROCS)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_en   (issue),
		.rd_addr (scan_idx_q[IdxW-1:0]),
		.rd_data (rd_data)
	);

	assign rd_rec = entry_t'(rd_data);

	// aged key without the common time term: prio * div + arrival
	assign prod   = div_q * rd_rec.prio;
	assign key_c  = {1'b0, prod} + {1'b0, rd_rec.arrival};
	assign elig_c = (rd_rec.arrival <= time_q) && !done_q[ridx_s1];

	assign better = !found_q || (key_s2 < best_key_q) ||
		((key_s2 == best_key_q) && (rec_s2.id < best_rec_q.id));

	// scan control and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rv_s1      <= 1'b0;
			v_s2       <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rv_s1 <= issue;
			v_s2  <= rv_s1;
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (v_s2 && elig_s2) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// scan payload stages and best entry
	always_ff @(posedge clk) begin
		ridx_s1 <= scan_idx_q[IdxW-1:0];
		elig_s2 <= elig_c;
		key_s2  <= key_c;
		rec_s2  <= rd_rec;
		idx_s2  <= ridx_s1;
		if (v_s2 && elig_s2 && better) begin
			best_key_q <= key_s2;
			best_rec_q <= rec_s2;
			best_idx_q <= idx_s2;
		end
	end

	// service of the picked entry for one unit
	always_comb begin
		time_inc = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
		start_v  = started_q[best_idx_q] ? best_rec_q.start : time_q;
		rem_new  = (best_rec_q.remaining != '0) ? best_rec_q.remaining - 1'b1 : '0;
		turn     = time_inc - best_rec_q.arrival;
		resp     = start_v - best_rec_q.arrival;
		waited   = (turn >= best_rec_q.burst) ? turn - best_rec_q.burst : '0;
		upd_rec           = best_rec_q;
		upd_rec.remaining = rem_new;
		upd_rec.start     = start_v;
	end

	// ram write: add at the fill count, write-back at the pick
	assign wr_en   = add_wr || upd_wr;
	assign wr_addr = cmd.do_add ? count_q[IdxW-1:0] : best_idx_q;
	assign wr_rec  = cmd.do_add ? in_rec_q : upd_rec;

	// fill count, time and per-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			time_q    <= '0;
			started_q <= '0;
			done_q    <= '0;
		end else if (cmd.do_clear) begin
			count_q   <= '0;
			time_q    <= '0;
			started_q <= '0;
			done_q    <= '0;
		end else if (add_wr) begin
			count_q                     <= count_q + 1'b1;
			started_q[count_q[IdxW-1:0]] <= 1'b0;
			done_q[count_q[IdxW-1:0]]    <= 1'b0;
		end else if (cmd.commit) begin
			time_q <= time_inc;
			if (found_q) begin
				started_q[best_idx_q] <= 1'b1;
				if (rem_new == '0) begin
					done_q[best_idx_q] <= 1'b1;
				end
			end
		end
	end

	// result formation
	always_comb begin
		result_c           = '0;
		result_c.tick_time = time_q;
		if (cmd.do_add) begin
			result_c.code = table_full ? RC_FULL : RC_ADDED;
		end else if (cmd.do_clear) begin
			result_c.code = RC_CLEARED;
		end else if (found_q) begin
			result_c.code   = RC_RAN;
			result_c.run_id = best_rec_q.id;
			if (rem_new == '0) begin
				result_c.finished        = 1'b1;
				result_c.finish_time     = time_inc;
				result_c.response_time   = resp;
				result_c.waiting_time    = waited;
				result_c.turnaround_time = turn;
			end
		end else begin
			result_c.code = RC_IDLE;
		end
	end

	assign load_result = cmd.do_add || cmd.do_clear || cmd.commit;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_result) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= result_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign result    = result_q;

	// status to controller
	assign sts.cmd       = cmd_q;
	assign sts.out_free  = !rsp_valid_q || rsp_ready;
	assign sts.scan_done = (scan_idx_q >= count_q) && !rv_s1 && !v_s2;
endmodule

/* design/ppas_ctrl.sv */
module ppas_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppas_pkg::ctrl_sts_t sts,
	output ppas_pkg::ctrl_cmd_t cmd
);
	import ppas_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.cmd)
					CMD_ADD: begin
						if (sts.out_free) begin
							cmd.do_add = 1'b1;
							state_d    = S_IDLE;
						end
					end
					CMD_CLEAR: begin
						if (sts.out_free) begin
							cmd.do_clear = 1'b1;
							state_d      = S_IDLE;
						end
					end
					CMD_TICK: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					default: begin
						// reserved code: dropped without a result
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

/* design/preemptive_priority_aging_scheduler_core.sv */
// channel | dir | payload
// req     | in  | command, proc_id, arrival_time, burst_length, base_priority
// rsp     | out | status, tick_time, run_id, finished, finish/response/waiting/turnaround
// cfg     | in  | cfg_wr_en, cfg_wr_data (aging divisor)
//
// add, clear: result registered from dispatch, once the output register is free
// tick: dispatch starts a scan of the N filled entries, N the fill count, and commit
// registers the result; the entry ram gives one entry per cycle to the scan
// one item at a time; a waiting result does not block the next request transfer
// arst_n clears control, fill count, time, entry flags; divisor resets to 20
// a full output register holds the block in dispatch or commit until it drains
`include "preemptive_priority_aging_scheduler_core_defines.svh"

module preemptive_priority_aging_scheduler_core #(
	parameter int MAX_PROCS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ppas_req_if.sink                   req,
	ppas_rsp_if.source                 rsp,
	input  logic                       cfg_wr_en,
	input  logic [ppas_pkg::DIV_W-1:0] cfg_wr_data
);
	import ppas_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	ctrl_sts_t ctrl_sts;
	result_t   result;
	logic      in_ready;

	// controller
	ppas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (ctrl_sts),
		.cmd      (ctrl_cmd)
	);

	// datapath
	ppas_datapath #(
		.MAX_PROCS (MAX_PROCS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctrl_cmd),
		.sts           (ctrl_sts),
		.command       (req.command),
		.proc_id       (req.proc_id),
		.arrival_time  (req.arrival_time),
		.burst_length  (req.burst_length),
		.base_priority (req.base_priority),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.result        (result)
	);

	// channel wiring
	assign req.ready           = in_ready;
	assign rsp.status          = result.code;
	assign rsp.tick_time       = result.tick_time;
	assign rsp.run_id          = result.run_id;
	assign rsp.finished        = result.finished;
	assign rsp.finish_time     = result.finish_time;
	assign rsp.response_time   = result.response_time;
	assign rsp.waiting_time    = result.waiting_time;
	assign rsp.turnaround_time = result.turnaround_time;

	// checks
	`PPAS_ASSERT_IMPL(a_load_needs_room, clk, arst_n, (ctrl_cmd.do_add || ctrl_cmd.do_clear || ctrl_cmd.commit), ctrl_sts.out_free)
	`PPAS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, (req.valid && req.ready), !req.ready)
	`PPAS_ASSERT_NEXT(a_result_after_load, clk, arst_n, (ctrl_cmd.do_add || ctrl_cmd.do_clear || ctrl_cmd.commit), rsp.valid)
endmodule

/* tb/ppas_schedule_checker.sv */
`timescale 1ns / 100ps

// watches the request and response channels, predicts every result and compares it
module ppas_schedule_checker
	import ppas_pkg::*;
#(
	parameter int MAX_PROCS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	ppas_req_if              req,
	ppas_rsp_if              rsp,
	input  logic             cfg_wr_en,
	input  logic [DIV_W-1:0] cfg_wr_data,
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRI_W-1:0]  prio;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] start;
		bit                started;
		bit                done;
	} proc_slot_t;

	proc_slot_t        slots [MAX_PROCS];
	int unsigned       fill;
	logic [TIME_W-1:0] now_t;
	logic [DIV_W-1:0]  divisor;
	result_t           due_results [$];
	result_t           want;

	task automatic note_failure(input string what);
		$display("%0t: scheduler check: %s", $time, what);
		errors++;
	endtask

	task automatic compare_field(input string name, input int unsigned got,
			input int unsigned exp_val);
		if (got != exp_val)
			note_failure($sformatf("%s got %0d expected %0d", name, got, exp_val));
	endtask

	function automatic void empty_table();
		for (int i = 0; i < MAX_PROCS; i++) begin
			slots[i].started = 1'b0;
			slots[i].done    = 1'b0;
		end
		fill  = 0;
		now_t = '0;
	endfunction

	// applies one command to the shadow table and returns the result it gives
	function automatic result_t schedule_command(input cmd_t cmd, input logic [ID_W-1:0] pid,
			input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] burst,
			input logic [PRI_W-1:0] prio);
		result_t           r;
		bit                found;
		int                best;
		int                aged;
		int unsigned       pick;
		logic [TIME_W-1:0] turn;
		r = '0;
		r.tick_time = now_t;
		found = 1'b0;
		best = 0;
		pick = 0;
		case (cmd)
			CMD_ADD: begin
				if (fill >= MAX_PROCS) begin
					r.code = RC_FULL;
				end else begin
					slots[fill].id        = pid;
					slots[fill].arrival   = arr;
					slots[fill].burst     = burst;
					slots[fill].prio      = prio;
					slots[fill].remaining = burst;
					slots[fill].start     = '0;
					slots[fill].started   = 1'b0;
					slots[fill].done      = 1'b0;
					fill++;
					r.code = RC_ADDED;
				end
			end
			CMD_TICK: begin
				// smallest aged priority among arrived unfinished entries, lower pid on a tie
				for (int unsigned i = 0; i < fill; i++) begin
					if (slots[i].arrival <= now_t && !slots[i].done) begin
						aged = int'(slots[i].prio) * int'(divisor)
							- (int'(now_t) - int'(slots[i].arrival));
						if (!found || aged < best ||
								(aged == best && slots[i].id < slots[pick].id)) begin
							found = 1'b1;
							best  = aged;
							pick  = i;
						end
					end
				end
				if (!found) begin
					r.code = RC_IDLE;
					if (now_t != TIME_MAX)
						now_t++;
				end else begin
					r.code   = RC_RAN;
					r.run_id = slots[pick].id;
					if (!slots[pick].started) begin
						slots[pick].started = 1'b1;
						slots[pick].start   = now_t;
					end
					if (slots[pick].remaining != '0)
						slots[pick].remaining--;
					if (now_t != TIME_MAX)
						now_t++;
					if (slots[pick].remaining == '0) begin
						turn = now_t - slots[pick].arrival;
						slots[pick].done  = 1'b1;
						r.finished        = 1'b1;
						r.finish_time     = now_t;
						r.response_time   = slots[pick].start - slots[pick].arrival;
						r.turnaround_time = turn;
						// turnaround can fall below the burst only once time has saturated
						r.waiting_time    = (turn >= slots[pick].burst) ?
							turn - slots[pick].burst : '0;
					end
				end
			end
			CMD_CLEAR: begin
				empty_table();
				r.code = RC_CLEARED;
			end
			default: ;
		endcase
		return r;
	endfunction

	// result transfers are matched before the request transfer of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_table();
			divisor = DIV_RESET;
			due_results.delete();
			pending = 0;
		end else begin
			if (cfg_wr_en)
				divisor = cfg_wr_data;
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					note_failure($sformatf("result with nothing expected, status %0d",
						rsp.status));
				end else begin
					want = due_results.pop_front();
					compare_field("status", 32'(rsp.status), 32'(want.code));
					compare_field("tick_time", 32'(rsp.tick_time), 32'(want.tick_time));
					compare_field("run_id", 32'(rsp.run_id), 32'(want.run_id));
					compare_field("finished", 32'(rsp.finished), 32'(want.finished));
					compare_field("finish_time", 32'(rsp.finish_time),
						32'(want.finish_time));
					compare_field("response_time", 32'(rsp.response_time),
						32'(want.response_time));
					compare_field("waiting_time", 32'(rsp.waiting_time),
						32'(want.waiting_time));
					compare_field("turnaround_time", 32'(rsp.turnaround_time),
						32'(want.turnaround_time));
				end
			end
			if (req.valid && req.ready && cmd_t'(req.command) != CMD_NONE)
				due_results.insert(due_results.size(),
					schedule_command(cmd_t'(req.command), req.proc_id,
					req.arrival_time, req.burst_length, req.base_priority));
			pending = due_results.size();
		end
	end

endmodule

/* tb/preemptive_priority_aging_scheduler_core_tb.sv */
`timescale 1ns / 100ps

module preemptive_priority_aging_scheduler_core_tb;
	import ppas_pkg::*;

	localparam int MAX_PROCS     = 16;
	localparam int TRAFFIC_ITEMS = 630;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 2 * MAX_PROCS + 16;
	localparam int LIMIT_CYCLES  = 4000000;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [DIV_W-1:0] cfg_wr_data;
	int               errors;
	int               pending;

	int src_gap_pct  = 0;
	int sink_gap_pct = 0;
	int hold_asks    = 0;
	int holds_done   = 0;
	int sched_now    = 0;
	int sched_fill   = 0;
	int cycles       = 0;

	ppas_req_if req_ch ();
	ppas_rsp_if rsp_ch ();

	preemptive_priority_aging_scheduler_core #(
		.MAX_PROCS(MAX_PROCS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	ppas_schedule_checker #(
		.MAX_PROCS(MAX_PROCS)
	) sched_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.errors(errors),
		.pending(pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("preemptive_priority_aging_scheduler_core_tb: errors");
		$finish;
	end

	// response side: random back-pressure, plus a long hold-off when asked for
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				rsp_ch.ready = 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(negedge clk);
				holds_done++;
			end
			rsp_ch.ready = ($urandom_range(99) >= sink_gap_pct);
		end
	end

	// one request transfer; called and left at a falling edge, valid stays up for the next call
	task automatic issue(input cmd_t cmd, input logic [ID_W-1:0] pid,
			input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] burst,
			input logic [PRI_W-1:0] prio);
		while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid         = 1'b1;
		req_ch.command       = cmd;
		req_ch.proc_id       = pid;
		req_ch.arrival_time  = arr;
		req_ch.burst_length  = burst;
		req_ch.base_priority = prio;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		case (cmd)
			CMD_ADD:   sched_fill++;
			CMD_TICK:  sched_now++;
			CMD_CLEAR: begin
				sched_now  = 0;
				sched_fill = 0;
			end
			default: ;
		endcase
	endtask

	// stop offering, let every result drain and the block go quiet
	task automatic settle();
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_divisor(input logic [DIV_W-1:0] value);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	// mostly well-formed schedules around the current time, some noise and clears
	task automatic run_traffic(input int items);
		int sent;
		int roll;
		int arr;
		sent = 0;
		while (sent < items) begin
			roll = $urandom_range(99);
			if (sched_fill >= MAX_PROCS && $urandom_range(3) == 0)
				roll = 0;
			if (roll < 3) begin
				issue(CMD_CLEAR, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
					PRI_W'($urandom));
				sent++;
			end else if (roll < 5) begin
				issue(CMD_NONE, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
					PRI_W'($urandom));
			end else if (roll < 8) begin
				issue(CMD_ADD, ID_W'($urandom), TIME_W'($urandom),
					TIME_W'($urandom_range(65535, 1)), PRI_W'($urandom));
				sent++;
			end else if (roll < 45) begin
				arr = sched_now + int'($urandom_range(6)) - int'($urandom_range(8));
				if (arr < 0)
					arr = 0;
				issue(CMD_ADD,
					ID_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7)),
					TIME_W'(arr),
					TIME_W'(($urandom_range(4) == 0) ? $urandom_range(40, 1) :
						$urandom_range(6, 1)),
					PRI_W'(($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(255)));
				sent++;
			end else begin
				issue(CMD_TICK, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
					PRI_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		req_ch.valid         = 1'b0;
		req_ch.command       = CMD_ADD;
		req_ch.proc_id       = '0;
		req_ch.arrival_time  = '0;
		req_ch.burst_length  = '0;
		req_ch.base_priority = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle tick, field extremes, pid ties, duplicate pids, full table,
		// unknown command and clear, all under the reset divisor
		issue(CMD_TICK, '0, '0, '0, '0);
		issue(CMD_ADD, 8'd255, 16'd0, 16'd1, 8'd255);
		issue(CMD_ADD, 8'd0, 16'hFFFF, 16'hFFFF, 8'd0);
		issue(CMD_ADD, 8'd7, 16'd0, 16'd3, 8'd0);
		issue(CMD_ADD, 8'd7, 16'd0, 16'd2, 8'd0);
		issue(CMD_ADD, 8'd9, 16'd1, 16'd1, 8'd0);
		repeat (4) issue(CMD_TICK, '0, '0, '0, '0);
		repeat (11) issue(CMD_ADD, ID_W'($urandom_range(255)),
			TIME_W'($urandom_range(sched_now)), TIME_W'($urandom_range(4, 1)),
			PRI_W'($urandom_range(3)));
		issue(CMD_ADD, 8'd42, 16'd0, 16'd1, 8'd0);
		issue(CMD_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		issue(CMD_CLEAR, '0, '0, '0, '0);
		settle();

		// sender idles little, receiver a lot, with one long hold-off at the start
		write_divisor(8'd1);
		src_gap_pct  = 14;
		sink_gap_pct = 66;
		hold_asks++;
		run_traffic(TRAFFIC_ITEMS);
		settle();

		// the other way round
		write_divisor(8'd255);
		src_gap_pct  = 66;
		sink_gap_pct = 14;
		run_traffic(TRAFFIC_ITEMS);
		settle();

		// no idling on either side
		write_divisor(DIV_W'($urandom_range(254, 2)));
		src_gap_pct  = 0;
		sink_gap_pct = 0;
		run_traffic(TRAFFIC_ITEMS);
		settle();

		if (errors == 0 && pending == 0)
			$display("preemptive_priority_aging_scheduler_core_tb: clean");
		else
			$display("preemptive_priority_aging_scheduler_core_tb: errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/ppas_pkg.sv
design/ppas_if.sv
design/ppas_ram.sv
design/ppas_datapath.sv
design/ppas_ctrl.sv
design/preemptive_priority_aging_scheduler_core.sv
tb/ppas_schedule_checker.sv
tb/preemptive_priority_aging_scheduler_core_tb.sv
